FILE: rtl/rsi_pkg.sv
// Shared widths, constants and control structs for the RSI unit.
`default_nettype none

package rsi_pkg;

    localparam int PRICE_W  = 32;                 // Q16.16 price
    localparam int PERIOD_W = 10;
    localparam int RSI_W    = 23;                 // Q7.16 result
    localparam int ITEMS_W  = 11;
    localparam int AVG_W    = 48;                 // running sums / averages
    localparam int PROD_W   = AVG_W + PERIOD_W;   // avg * (period - 1)
    localparam int NUM_W    = PROD_W + 1;         // product plus one change
    localparam int DVD_W    = 64;                 // divider dividend / quotient register
    localparam int REM_W    = 41;                 // divider remainder and divisor
    localparam int SUM_W    = AVG_W + 1;          // gain + loss before scaling down
    localparam int FRAC_W   = 16;
    localparam int CNT_W    = 6;

    localparam logic [ITEMS_W-1:0]  ITEMS_CAP    = 11'd2047;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd14;
    localparam logic [PERIOD_W-1:0] PERIOD_ONE   = 10'd1;
    localparam logic [PERIOD_W-1:0] RSI_SCALE    = 10'd100;
    localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;
    localparam logic [RSI_W-1:0]    RSI_HALF     = 23'd3276800;

    // counter load values: number of steps minus one
    localparam logic [CNT_W-1:0] MUL_LAST     = 6'd9;
    localparam logic [CNT_W-1:0] AVG_DIV_LAST = 6'd58;
    localparam logic [CNT_W-1:0] RSI_DIV_LAST = 6'd22;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

`default_nettype wire

FILE: rtl/rsi_intf.sv
// Valid/ready channel interfaces for price input and RSI output.
`default_nettype none

interface rsi_in_if;
    logic                        valid;
    logic                        ready;
    logic [rsi_pkg::PRICE_W-1:0] price;
    logic                        price_missing;

    modport source (output valid, output price, output price_missing, input ready);
    modport sink   (input valid, input price, input price_missing, output ready);
endinterface

interface rsi_out_if;
    logic                      valid;
    logic                      ready;
    logic [rsi_pkg::RSI_W-1:0] rsi;
    logic                      rsi_valid;
    logic                      missing_mid_stream;

    modport source (output valid, output rsi, output rsi_valid, output missing_mid_stream,
                    input ready);
    modport sink   (input valid, input rsi, input rsi_valid, input missing_mid_stream,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/rsi_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none

module rsi_smul (
    input  logic                          i_clk,
    input  rsi_pkg::t_mul_ctl             i_ctl,
    input  logic [rsi_pkg::AVG_W-1:0]     i_mcand,
    input  logic [rsi_pkg::PERIOD_W-1:0]  i_mplier,
    output logic [rsi_pkg::PROD_W-1:0]    o_product
);

    logic [rsi_pkg::PROD_W-1:0]   r_acc,    n_acc;
    logic [rsi_pkg::AVG_W-1:0]    r_mcand,  n_mcand;
    logic [rsi_pkg::PERIOD_W-1:0] r_mplier, n_mplier;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_ctl.load) begin
            n_acc    = '0;
            n_mcand  = i_mcand;
            n_mplier = i_mplier;
        end else if (i_ctl.step) begin
            n_acc = {r_acc[rsi_pkg::PROD_W-2:0], 1'b0}
                  + (r_mplier[rsi_pkg::PERIOD_W-1]
                     ? {{(rsi_pkg::PROD_W-rsi_pkg::AVG_W){1'b0}}, r_mcand}
                     : {rsi_pkg::PROD_W{1'b0}});
            n_mplier = {r_mplier[rsi_pkg::PERIOD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_product = r_acc;

endmodule

`default_nettype wire

FILE: rtl/rsi_sdiv.sv
// Restoring divider, one quotient bit per cycle; quotient shifts into the dividend register.
`default_nettype none

module rsi_sdiv (
    input  logic                        i_clk,
    input  rsi_pkg::t_div_ctl           i_ctl,
    input  logic [rsi_pkg::REM_W-1:0]   i_rem0,
    input  logic [rsi_pkg::DVD_W-1:0]   i_dvd0,
    input  logic [rsi_pkg::REM_W-1:0]   i_divisor,
    output logic [rsi_pkg::DVD_W-1:0]   o_quot
);

    logic [rsi_pkg::REM_W-1:0] r_rem,     n_rem;
    logic [rsi_pkg::DVD_W-1:0] r_dvd,     n_dvd;
    logic [rsi_pkg::REM_W-1:0] r_divisor, n_divisor;
    logic [rsi_pkg::REM_W:0]   w_shift;
    logic [rsi_pkg::REM_W:0]   w_diff;
    logic                      w_ge;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    assign w_shift = {r_rem, r_dvd[rsi_pkg::DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_divisor};
    assign w_ge    = ~w_diff[rsi_pkg::REM_W];

    always_comb begin
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_divisor = r_divisor;
        if (i_ctl.load) begin
            n_rem     = i_rem0;
            n_dvd     = i_dvd0;
            n_divisor = i_divisor;
        end else if (i_ctl.step) begin
            n_rem = w_ge ? w_diff[rsi_pkg::REM_W-1:0] : w_shift[rsi_pkg::REM_W-1:0];
            n_dvd = {r_dvd[rsi_pkg::DVD_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_divisor <= n_divisor;
    end

    assign o_quot = r_dvd;

endmodule

`default_nettype wire

FILE: rtl/relative_strength_index_unit.sv
// Top level of the Wilder RSI unit: sequencer, state and bit-serial datapath lanes.
`default_nettype none

// Wilder relative strength index over a stream of unsigned Q16.16 closing prices. The first
// price is only stored; each later price yields a gain or a loss (no change counts as loss).
// The first 'period' changes are summed and then divided by the period; afterwards each
// average becomes (avg*(period-1)+change)/period, truncated. Every item returns exactly one
// result transaction: rsi in Q7.16 (rounded to nearest), rsi_valid low during warm-up and for
// null prices, missing_mid_stream high for a null price after data has started. Period 0 acts
// as 1. Timing: one item at a time. A null, first or warm-up price passes from the input
// transaction through ST_DONE into the output register. A smoothed item runs through the
// bit-serial lanes: shift-add multiply, add, restoring division for both averages in
// parallel, storing the averages, the special-case check plus range scaling, the x100
// multiply, add, RSI division, taking the quotient and handing over. With a zero loss
// average the ratio is skipped. The item that forms the first averages skips the first
// multiply and its add. A finished result sits in the output register, so the next price
// is taken while it waits. The period register may be written whenever the unit is idle;
// writes are always taken, and one made while idle applies from the next price.
module relative_strength_index_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rsi_pkg::PERIOD_W-1:0]  i_cfg_period,
    rsi_in_if.sink                        i_in,
    rsi_out_if.source                     o_out
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_MUL  = 11'b000_0000_0010,   // avg * (period-1)
        ST_ADD  = 11'b000_0000_0100,   // + change, load dividers
        ST_DIV  = 11'b000_0000_1000,   // / period
        ST_AVG  = 11'b000_0001_0000,   // store averages
        ST_NORM = 11'b000_0010_0000,   // special cases, scale into range
        ST_RMUL = 11'b000_0100_0000,   // gain * 100
        ST_RADD = 11'b000_1000_0000,   // build rounded numerator
        ST_RDIV = 11'b001_0000_0000,
        ST_RFIN = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000    // wait for output register
    } t_state;

    // control state
    t_state                        r_state, n_state;
    logic [rsi_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [rsi_pkg::PERIOD_W-1:0]  r_period;
    logic [rsi_pkg::ITEMS_W-1:0]   r_items, n_items;
    logic [rsi_pkg::AVG_W-1:0]     r_gain_avg, n_gain_avg;
    logic [rsi_pkg::AVG_W-1:0]     r_loss_avg, n_loss_avg;
    logic                          r_out_valid, n_out_valid;

    // payload
    logic [rsi_pkg::PRICE_W-1:0]   r_last, n_last;
    logic [rsi_pkg::PRICE_W-1:0]   r_gain_x, n_gain_x;
    logic [rsi_pkg::PRICE_W-1:0]   r_loss_x, n_loss_x;
    logic [rsi_pkg::AVG_W-1:0]     r_ng, n_ng;
    logic [rsi_pkg::AVG_W-1:0]     r_nl, n_nl;
    logic [rsi_pkg::RSI_W-1:0]     r_res_rsi, n_res_rsi;
    logic                          r_res_valid, n_res_valid;
    logic                          r_res_miss, n_res_miss;
    logic [rsi_pkg::RSI_W-1:0]     r_out_rsi, n_out_rsi;
    logic                          r_out_rsi_valid, n_out_rsi_valid;
    logic                          r_out_miss, n_out_miss;

    logic                          w_acc;
    logic [rsi_pkg::PERIOD_W-1:0]  w_p;
    logic [rsi_pkg::PERIOD_W-1:0]  w_pm1;
    logic [rsi_pkg::ITEMS_W-1:0]   w_items_inc;
    logic                          w_warm;
    logic                          w_first;
    logic                          w_rise;
    logic [rsi_pkg::PRICE_W-1:0]   w_gain;
    logic [rsi_pkg::PRICE_W-1:0]   w_loss;
    logic [rsi_pkg::AVG_W-1:0]     w_sum_g;
    logic [rsi_pkg::AVG_W-1:0]     w_sum_l;
    logic [rsi_pkg::SUM_W-1:0]     w_nsum;
    logic                          w_big;
    logic [rsi_pkg::DVD_W-1:0]     w_rnum;
    logic                          w_last_step;
    logic                          w_out_free;

    // datapath lanes
    rsi_pkg::t_mul_ctl             w_mul_ctl;
    rsi_pkg::t_div_ctl             w_div_ctl;
    logic [rsi_pkg::AVG_W-1:0]     w_mcand_g;
    logic [rsi_pkg::PERIOD_W-1:0]  w_mplier;
    logic [rsi_pkg::PROD_W-1:0]    w_prod_g, w_prod_l;
    logic [rsi_pkg::NUM_W-1:0]     w_num_g, w_num_l;
    logic [rsi_pkg::REM_W-1:0]     w_rem0_g;
    logic [rsi_pkg::DVD_W-1:0]     w_dvd0_g, w_dvd0_l;
    logic [rsi_pkg::REM_W-1:0]     w_divisor_g, w_divisor_p;
    logic [rsi_pkg::DVD_W-1:0]     w_quot_g, w_quot_l;

    assign o_cfg_ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_last_step = (r_cnt == '0);

    // effective period: zero behaves as one
    assign w_p   = (r_period == '0) ? rsi_pkg::PERIOD_ONE : r_period;
    assign w_pm1 = w_p - rsi_pkg::PERIOD_ONE;

    assign w_items_inc = (r_items == rsi_pkg::ITEMS_CAP) ? r_items
                       : r_items + {{(rsi_pkg::ITEMS_W-1){1'b0}}, 1'b1};
    assign w_warm  = w_items_inc <= {1'b0, w_p};
    assign w_first = w_items_inc == ({1'b0, w_p} + {{(rsi_pkg::ITEMS_W-1){1'b0}}, 1'b1});

    assign w_rise = i_in.price > r_last;
    assign w_gain = w_rise ? i_in.price - r_last : '0;
    assign w_loss = w_rise ? '0 : r_last - i_in.price;

    // sums wrap at the average width
    assign w_sum_g = r_gain_avg
                   + {{(rsi_pkg::AVG_W-rsi_pkg::PRICE_W){1'b0}}, w_gain};
    assign w_sum_l = r_loss_avg
                   + {{(rsi_pkg::AVG_W-rsi_pkg::PRICE_W){1'b0}}, w_loss};

    // scaling: gain+loss must stay below 2^REM_W for the RSI divider
    assign w_nsum = {1'b0, r_ng} + {1'b0, r_nl};
    assign w_big  = |w_nsum[rsi_pkg::SUM_W-1:rsi_pkg::REM_W];

    // rounded numerator: gain*100*2^16 + sum/2
    assign w_rnum = {w_prod_g[rsi_pkg::AVG_W-1:0], {rsi_pkg::FRAC_W{1'b0}}}
                  + {{(rsi_pkg::DVD_W-rsi_pkg::REM_W+1){1'b0}},
                     w_nsum[rsi_pkg::REM_W-1:1]};

    // multiplier operands
    assign w_mcand_g = (r_state == ST_NORM) ? r_ng : r_gain_avg;
    assign w_mplier  = (r_state == ST_NORM) ? rsi_pkg::RSI_SCALE : w_pm1;

    // average numerators: first average from the accept cycle, later ones after the multiply
    assign w_num_g = (r_state == ST_ADD)
        ? {1'b0, w_prod_g} + {{(rsi_pkg::NUM_W-rsi_pkg::PRICE_W){1'b0}}, r_gain_x}
        : {{(rsi_pkg::NUM_W-rsi_pkg::AVG_W){1'b0}}, w_sum_g};
    assign w_num_l = (r_state == ST_ADD)
        ? {1'b0, w_prod_l} + {{(rsi_pkg::NUM_W-rsi_pkg::PRICE_W){1'b0}}, r_loss_x}
        : {{(rsi_pkg::NUM_W-rsi_pkg::AVG_W){1'b0}}, w_sum_l};

    assign w_divisor_p = {{(rsi_pkg::REM_W-rsi_pkg::PERIOD_W){1'b0}}, w_p};
    assign w_dvd0_l    = {w_num_l, {(rsi_pkg::DVD_W-rsi_pkg::NUM_W){1'b0}}};

    // gain lane doubles as the RSI divider
    always_comb begin
        if (r_state == ST_RADD) begin
            w_rem0_g    = w_rnum[rsi_pkg::DVD_W-1:rsi_pkg::RSI_W];
            w_dvd0_g    = {w_rnum[rsi_pkg::RSI_W-1:0], {rsi_pkg::REM_W{1'b0}}};
            w_divisor_g = w_nsum[rsi_pkg::REM_W-1:0];
        end else begin
            w_rem0_g    = '0;
            w_dvd0_g    = {w_num_g, {(rsi_pkg::DVD_W-rsi_pkg::NUM_W){1'b0}}};
            w_divisor_g = w_divisor_p;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_items         = r_items;
        n_gain_avg      = r_gain_avg;
        n_loss_avg      = r_loss_avg;
        n_last          = r_last;
        n_gain_x        = r_gain_x;
        n_loss_x        = r_loss_x;
        n_ng            = r_ng;
        n_nl            = r_nl;
        n_res_rsi       = r_res_rsi;
        n_res_valid     = r_res_valid;
        n_res_miss      = r_res_miss;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_rsi       = r_out_rsi;
        n_out_rsi_valid = r_out_rsi_valid;
        n_out_miss      = r_out_miss;
        w_mul_ctl       = '0;
        w_div_ctl       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_res_rsi   = '0;
                    n_res_valid = 1'b0;
                    n_res_miss  = 1'b0;
                    if (i_in.price_missing) begin
                        // null price: no state change
                        n_res_miss = (r_items != '0);
                        n_state    = ST_DONE;
                    end else if (r_items == '0) begin
                        n_items = {{(rsi_pkg::ITEMS_W-1){1'b0}}, 1'b1};
                        n_last  = i_in.price;
                        n_state = ST_DONE;
                    end else begin
                        n_items  = w_items_inc;
                        n_last   = i_in.price;
                        n_gain_x = w_gain;
                        n_loss_x = w_loss;
                        if (w_warm) begin
                            n_gain_avg = w_sum_g;
                            n_loss_avg = w_sum_l;
                            n_state    = ST_DONE;
                        end else if (w_first) begin
                            w_div_ctl.load = 1'b1;
                            n_cnt          = rsi_pkg::AVG_DIV_LAST;
                            n_state        = ST_DIV;
                        end else begin
                            w_mul_ctl.load = 1'b1;
                            n_cnt          = rsi_pkg::MUL_LAST;
                            n_state        = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                w_mul_ctl.step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (w_last_step) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                w_div_ctl.load = 1'b1;
                n_cnt          = rsi_pkg::AVG_DIV_LAST;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                w_div_ctl.step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (w_last_step) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG: begin
                n_gain_avg = w_quot_g[rsi_pkg::AVG_W-1:0];
                n_loss_avg = w_quot_l[rsi_pkg::AVG_W-1:0];
                n_ng       = w_quot_g[rsi_pkg::AVG_W-1:0];
                n_nl       = w_quot_l[rsi_pkg::AVG_W-1:0];
                n_state    = ST_NORM;
            end
            ST_NORM: begin
                n_res_valid = 1'b1;
                n_res_miss  = 1'b0;
                if (r_ng == '0 && r_nl == '0) begin
                    n_res_rsi = rsi_pkg::RSI_HALF;
                    n_state   = ST_DONE;
                end else if (r_nl == '0) begin
                    n_res_rsi = rsi_pkg::RSI_FULL;
                    n_state   = ST_DONE;
                end else if (w_big) begin
                    n_ng = {1'b0, r_ng[rsi_pkg::AVG_W-1:1]};
                    n_nl = {1'b0, r_nl[rsi_pkg::AVG_W-1:1]};
                end else begin
                    w_mul_ctl.load = 1'b1;
                    n_cnt          = rsi_pkg::MUL_LAST;
                    n_state        = ST_RMUL;
                end
            end
            ST_RMUL: begin
                w_mul_ctl.step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (w_last_step) begin
                    n_state = ST_RADD;
                end
            end
            ST_RADD: begin
                w_div_ctl.load = 1'b1;
                n_cnt          = rsi_pkg::RSI_DIV_LAST;
                n_state        = ST_RDIV;
            end
            ST_RDIV: begin
                w_div_ctl.step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (w_last_step) begin
                    n_state = ST_RFIN;
                end
            end
            ST_RFIN: begin
                n_res_rsi = w_quot_g[rsi_pkg::RSI_W-1:0];
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_rsi       = r_res_rsi;
                    n_out_rsi_valid = r_res_valid;
                    n_out_miss      = r_res_miss;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_period    <= rsi_pkg::PERIOD_RESET;
            r_items     <= '0;
            r_gain_avg  <= '0;
            r_loss_avg  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_items     <= n_items;
            r_gain_avg  <= n_gain_avg;
            r_loss_avg  <= n_loss_avg;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_period <= i_cfg_period;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last          <= n_last;
        r_gain_x        <= n_gain_x;
        r_loss_x        <= n_loss_x;
        r_ng            <= n_ng;
        r_nl            <= n_nl;
        r_res_rsi       <= n_res_rsi;
        r_res_valid     <= n_res_valid;
        r_res_miss      <= n_res_miss;
        r_out_rsi       <= n_out_rsi;
        r_out_rsi_valid <= n_out_rsi_valid;
        r_out_miss      <= n_out_miss;
    end

    rsi_smul u_mul_gain (
        .i_clk     (i_clk),
        .i_ctl     (w_mul_ctl),
        .i_mcand   (w_mcand_g),
        .i_mplier  (w_mplier),
        .o_product (w_prod_g)
    );

    rsi_smul u_mul_loss (
        .i_clk     (i_clk),
        .i_ctl     (w_mul_ctl),
        .i_mcand   (r_loss_avg),
        .i_mplier  (w_mplier),
        .o_product (w_prod_l)
    );

    rsi_sdiv u_div_gain (
        .i_clk     (i_clk),
        .i_ctl     (w_div_ctl),
        .i_rem0    (w_rem0_g),
        .i_dvd0    (w_dvd0_g),
        .i_divisor (w_divisor_g),
        .o_quot    (w_quot_g)
    );

    rsi_sdiv u_div_loss (
        .i_clk     (i_clk),
        .i_ctl     (w_div_ctl),
        .i_rem0    ({rsi_pkg::REM_W{1'b0}}),
        .i_dvd0    (w_dvd0_l),
        .i_divisor (w_divisor_p),
        .o_quot    (w_quot_l)
    );

    assign o_out.valid              = r_out_valid;
    assign o_out.rsi                = r_out_rsi;
    assign o_out.rsi_valid          = r_out_rsi_valid;
    assign o_out.missing_mid_stream = r_out_miss;

`ifndef NO_ASSERTIONS
    a_null_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.price_missing)
        |=> ($stable(r_items) && $stable(r_gain_avg) && $stable(r_loss_avg)))
        else $error("null price changed the smoothing state");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.rsi_valid) |-> (o_out.rsi == '0))
        else $error("invalid result carries a non-zero rsi");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.rsi <= rsi_pkg::RSI_FULL))
        else $error("rsi above 100");

    a_rfin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RFIN) |-> ($past(r_state) == ST_RDIV))
        else $error("rsi quotient taken without a division");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (o_out.valid && r_state == ST_IDLE))
        else $error("finished transaction not moved to the output register");
`endif

endmodule

`default_nettype wire
